[hw/rtl/timer_drift_sync_corrector_top_macros.svh]
// assertion helpers, clocked on clk and disabled during rst
`ifndef TIMER_DRIFT_SYNC_CORRECTOR_TOP_MACROS_SVH
`define TIMER_DRIFT_SYNC_CORRECTOR_TOP_MACROS_SVH

// condition that must hold at every edge
`define TDSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge forces the consequent at the next
`define TDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// antecedent forces the consequent at the same edge
`define TDSC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/tdsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdsc_pkg;

  localparam int AVG_DEPTH_DEF = 4;
  localparam int TIMER_BITS    = 16;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  // event codes
  localparam logic [1:0] OP_SYNC = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  // register indexes
  localparam logic [2:0] REG_PRESENCE_RELOAD   = 3'd0;
  localparam logic [2:0] REG_CORRECTION_PERIOD = 3'd1;
  localparam logic [2:0] REG_WINDOW_LOW        = 3'd2;
  localparam logic [2:0] REG_WINDOW_HIGH       = 3'd3;
  localparam logic [2:0] REG_START_VALUE       = 3'd4;

  // register reset values
  localparam logic [7:0]            PRESENCE_RELOAD_RST   = 8'd120;
  localparam logic [TIMER_BITS-1:0] CORRECTION_PERIOD_RST = 16'd1000;
  localparam logic [TIMER_BITS-1:0] WINDOW_LOW_RST        = 16'd5000;
  localparam logic [TIMER_BITS-1:0] WINDOW_HIGH_RST       = 16'd15000;
  localparam logic [TIMER_BITS-1:0] START_VALUE_RST       = 16'd2;

  localparam logic [TIMER_BITS-1:0] STEP_MAX = '1;

endpackage

`default_nettype wire

[hw/rtl/timer_drift_sync_corrector_top.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "timer_drift_sync_corrector_top_macros.svh"

// Drift corrector that keeps a local step timer locked to a reference timer.
// Each input transaction carries one event (sync pulse, step tick or correction
// poll) and yields exactly one result transaction. Sync pulses, ticks and polls
// that do not feed the moving average are accepted and then loaded into the
// result register. A poll that feeds the average runs a small sequencer over
// one shared adder: it reads and accumulates each stored sample, takes the
// magnitude, divides it by the fill count with a restoring division over
// SUM_W bits (SUM_W = 16 + clog2(AVG_DEPTH+1), 19 at the default depth), fixes
// the sign and hands off the result. The input stalls until each accepted
// transaction has been handed off; the output register holds a finished
// result until the receiver takes it.
// Configuration is an APB-style port, register i at byte address 4*i.
module timer_drift_sync_corrector_top #(
  parameter int AVG_DEPTH = tdsc_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tdsc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tdsc_pkg::DATA_W-1:0]  pwdata,
  output logic      [tdsc_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  // event input
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   op,
  input  wire logic [15:0]                  ref_count,
  input  wire logic [15:0]                  local_count,
  // result output
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              load_local,
  output logic      [15:0]                  new_local,
  output logic                              clear_ref,
  output logic signed [15:0]                correction_out,
  output logic                              cable_present,
  output logic                              sync_seen
);

  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = 16 + $clog2(AVG_DEPTH + 1);
  localparam int ALU_W  = SUM_W + 1;
  localparam int CNT_W  = $clog2(SUM_W);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_ACC  = 7'b0000100,
    ST_PREP = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_DONE = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0]  presence_reload;
  logic [15:0] correction_period;
  logic [15:0] window_low;
  logic [15:0] window_high;
  logic [15:0] start_value;

  // tracking state
  logic [7:0]  presence_left;
  logic [15:0] steps_since_fix;
  logic        fix_requested;
  logic        awaiting_first_pulse;
  logic        skip_next_sample;
  logic        pulse_seen;
  logic [15:0] drift_correction;

  // moving average storage, undefined until written
  logic [15:0]       avg_samples [AVG_DEPTH];
  logic [SLOT_W-1:0] avg_slot;
  logic [FILL_W-1:0] avg_fill;
  logic [15:0]       rd_data;

  // sequencer datapath
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  mag;
  logic [FILL_W-1:0] rem;
  logic              neg;
  logic [FILL_W-1:0] idx;
  logic [CNT_W-1:0]  div_cnt;

  // pending result fields
  logic        res_load;
  logic [15:0] res_new;
  logic        res_clr;

  // apb write decode
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[tdsc_pkg::ADDR_W-1:2];

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      tdsc_pkg::REG_PRESENCE_RELOAD:   prdata = {24'd0, presence_reload};
      tdsc_pkg::REG_CORRECTION_PERIOD: prdata = {16'd0, correction_period};
      tdsc_pkg::REG_WINDOW_LOW:        prdata = {16'd0, window_low};
      tdsc_pkg::REG_WINDOW_HIGH:       prdata = {16'd0, window_high};
      tdsc_pkg::REG_START_VALUE:       prdata = {16'd0, start_value};
      default:                         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_reload   <= tdsc_pkg::PRESENCE_RELOAD_RST;
      correction_period <= tdsc_pkg::CORRECTION_PERIOD_RST;
      window_low        <= tdsc_pkg::WINDOW_LOW_RST;
      window_high       <= tdsc_pkg::WINDOW_HIGH_RST;
      start_value       <= tdsc_pkg::START_VALUE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tdsc_pkg::REG_PRESENCE_RELOAD:   presence_reload   <= pwdata[7:0];
        tdsc_pkg::REG_CORRECTION_PERIOD: correction_period <= pwdata[15:0];
        tdsc_pkg::REG_WINDOW_LOW:        window_low        <= pwdata[15:0];
        tdsc_pkg::REG_WINDOW_HIGH:       window_high       <= pwdata[15:0];
        tdsc_pkg::REG_START_VALUE:       start_value       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // event decode helpers
  logic              accept;
  logic [15:0]       steps_inc;
  logic              in_window;
  logic              fix_now;
  logic [15:0]       diff;
  logic [SLOT_W-1:0] slot_next;
  logic [FILL_W-1:0] fill_next;
  logic              avg_start;
  logic              emit_fire;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign steps_inc = (steps_since_fix == tdsc_pkg::STEP_MAX) ? steps_since_fix
                                                             : steps_since_fix + 16'd1;
  assign in_window = (local_count > window_low) && (local_count < window_high);
  // a pending request inside the window is the only poll that does anything
  assign fix_now   = fix_requested && in_window;
  assign diff      = ref_count - local_count;
  assign slot_next = (avg_slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : avg_slot + SLOT_W'(1);
  assign fill_next = (avg_fill < FILL_W'(AVG_DEPTH)) ? avg_fill + FILL_W'(1) : avg_fill;
  // poll that stores a nonzero sample and recomputes the average
  assign avg_start = (op == tdsc_pkg::OP_POLL) && fix_now && (presence_left != 8'd0)
                     && !skip_next_sample && (diff != 16'd0);
  // result handed to the output register
  assign emit_fire = (state == ST_EMIT) && (!out_valid || !out_stall);

  // the one shared adder: accumulate, negate, trial subtract
  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic              alu_cin;
  logic [ALU_W-1:0]  alu_sum;
  logic [FILL_W:0]   rem_sh;
  logic              qbit;

  assign rem_sh = {rem, mag[SUM_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state)
      ST_ACC: begin
        alu_a = {acc[SUM_W-1], acc};
        alu_b = {{(ALU_W-16){rd_data[15]}}, rd_data};
      end
      ST_PREP: begin
        alu_b   = ~{acc[SUM_W-1], acc};
        alu_cin = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {{(ALU_W-FILL_W-1){1'b0}}, rem_sh};
        alu_b   = ~{{(ALU_W-FILL_W){1'b0}}, avg_fill};
        alu_cin = 1'b1;
      end
      ST_DONE: begin
        alu_b   = ~{1'b0, mag};
        alu_cin = 1'b1;
      end
      default: ;
    endcase
    alu_sum = alu_a + alu_b + {{(ALU_W-1){1'b0}}, alu_cin};
  end

  // no borrow from the trial subtract sets the quotient bit
  assign qbit = !alu_sum[ALU_W-1];

  // sample store, registered read port
  always_ff @(posedge clk) begin
    if (accept && avg_start) begin
      avg_samples[avg_slot] <= diff;
    end
    if (state == ST_READ) begin
      rd_data <= avg_samples[idx[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      presence_left        <= '0;
      steps_since_fix      <= '0;
      fix_requested        <= 1'b0;
      awaiting_first_pulse <= 1'b1;
      skip_next_sample     <= 1'b1;
      pulse_seen           <= 1'b0;
      drift_correction     <= '0;
      avg_slot             <= '0;
      avg_fill             <= '0;
      out_valid            <= 1'b0;
    end else begin
      // result loaded, or taken downstream
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= avg_start ? ST_READ : ST_EMIT;
            case (op)
              tdsc_pkg::OP_SYNC: begin
                if (awaiting_first_pulse) begin
                  awaiting_first_pulse <= 1'b0;
                end
                res_load      <= awaiting_first_pulse;
                res_new       <= awaiting_first_pulse ? start_value : 16'd0;
                res_clr       <= 1'b1;
                presence_left <= presence_reload;
                pulse_seen    <= 1'b1;
              end
              tdsc_pkg::OP_TICK: begin
                res_load <= 1'b0;
                res_new  <= '0;
                res_clr  <= 1'b0;
                if (presence_left != 8'd0) begin
                  presence_left <= presence_left - 8'd1;
                end
                steps_since_fix <= steps_inc;
                if (steps_inc >= correction_period) begin
                  fix_requested <= 1'b1;
                end
              end
              tdsc_pkg::OP_POLL: begin
                res_load <= fix_now;
                res_clr  <= 1'b0;
                if (fix_now) begin
                  fix_requested   <= 1'b0;
                  steps_since_fix <= '0;
                  if (presence_left != 8'd0) begin
                    res_new <= ref_count;
                    if (skip_next_sample) begin
                      // first difference after the cable returns
                      skip_next_sample <= 1'b0;
                    end else if (diff == 16'd0) begin
                      // zero difference restarts the average
                      avg_slot         <= '0;
                      avg_fill         <= '0;
                      drift_correction <= '0;
                    end else begin
                      avg_slot <= slot_next;
                      avg_fill <= fill_next;
                      acc      <= '0;
                      idx      <= '0;
                    end
                  end else begin
                    skip_next_sample <= 1'b1;
                    res_new          <= local_count + drift_correction;
                  end
                end else begin
                  res_new <= '0;
                end
              end
              default: begin
                res_load <= 1'b0;
                res_new  <= '0;
                res_clr  <= 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= alu_sum[SUM_W-1:0];
          idx <= idx + FILL_W'(1);
          if ((idx + FILL_W'(1)) == avg_fill) begin
            state <= ST_PREP;
          end else begin
            state <= ST_READ;
          end
        end
        ST_PREP: begin
          neg     <= acc[SUM_W-1];
          mag     <= acc[SUM_W-1] ? alu_sum[SUM_W-1:0] : acc;
          rem     <= '0;
          div_cnt <= CNT_W'(SUM_W - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem <= qbit ? alu_sum[FILL_W-1:0] : rem_sh[FILL_W-1:0];
          mag <= {mag[SUM_W-2:0], qbit};
          if (div_cnt == '0) begin
            state <= ST_DONE;
          end else begin
            div_cnt <= div_cnt - CNT_W'(1);
          end
        end
        ST_DONE: begin
          // quotient truncates toward zero, sign restored here
          drift_correction <= neg ? alu_sum[15:0] : mag[15:0];
          state            <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register, loaded when the transaction is handed off
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      load_local     <= res_load;
      new_local      <= res_new;
      clear_ref      <= res_clr;
      correction_out <= drift_correction;
      cable_present  <= (presence_left != 8'd0);
      sync_seen      <= pulse_seen;
    end
  end

  `TDSC_ASSERT_ALWAYS(a_fill_bound, avg_fill <= FILL_W'(AVG_DEPTH), "fill count beyond depth")
  `TDSC_ASSERT_ALWAYS(a_slot_bound, {1'b0, avg_slot} < (SLOT_W+1)'(AVG_DEPTH), "slot beyond depth")
  `TDSC_ASSERT_NEXT(a_accept_busy, accept, state != ST_IDLE, "accepted event left no work")
  `TDSC_ASSERT_IMPLY(a_div_rem, state == ST_DIV, avg_fill != '0 && rem < avg_fill, "bad remainder")
  `TDSC_ASSERT_IMPLY(a_read_range, state == ST_READ, idx < avg_fill, "sample read beyond fill")

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam int         AVG_SLOTS    = tdsc_pkg::AVG_DEPTH_DEF;
  localparam int         DRAIN_CYCLES = 48;
  localparam int         LONG_HOLD    = 300;       // receiver hold-off for backpressure
  localparam int         CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic               load;
    logic [15:0]        value;
    logic               clear;
    logic signed [15:0] corr;
    logic               present;
    logic               seen;
  } sync_result_t;

  logic clk;
  logic rst = 1'b1;

  // configuration port
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [tdsc_pkg::ADDR_W-1:0]     paddr   = '0;
  logic [tdsc_pkg::DATA_W-1:0]     pwdata  = '0;
  logic [tdsc_pkg::DATA_W-1:0]     prdata;
  logic                            pready;

  // event input
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  op          = '0;
  logic [15:0] ref_count   = '0;
  logic [15:0] local_count = '0;

  // result output
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               load_local;
  logic [15:0]        new_local;
  logic               clear_ref;
  logic signed [15:0] correction_out;
  logic               cable_present;
  logic               sync_seen;

  timer_drift_sync_corrector_top dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .ref_count      (ref_count),
    .local_count    (local_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .load_local     (load_local),
    .new_local      (new_local),
    .clear_ref      (clear_ref),
    .correction_out (correction_out),
    .cable_present  (cable_present),
    .sync_seen      (sync_seen)
  );

  // predictor copy of the registers
  logic [7:0]  cfg_presence = tdsc_pkg::PRESENCE_RELOAD_RST;
  logic [15:0] cfg_period   = tdsc_pkg::CORRECTION_PERIOD_RST;
  logic [15:0] cfg_win_lo   = tdsc_pkg::WINDOW_LOW_RST;
  logic [15:0] cfg_win_hi   = tdsc_pkg::WINDOW_HIGH_RST;
  logic [15:0] cfg_start    = tdsc_pkg::START_VALUE_RST;

  // predictor copy of the corrector state
  logic [7:0]         pres_left           = '0;
  logic [15:0]        step_count          = '0;
  logic               fix_pending         = 1'b0;
  logic               first_pulse_pending = 1'b1;
  logic               skip_sample         = 1'b1;
  logic               pulse_flag          = 1'b0;
  logic signed [15:0] corr_value          = '0;
  logic signed [15:0] avg_buf [AVG_SLOTS];
  logic [1:0]         avg_wr              = '0;
  logic [2:0]         avg_cnt             = '0;

  sync_result_t pending_results [$];

  int send_pct     = 0;
  int recv_pct     = 0;
  int failures     = 0;
  int cycle_count  = 0;
  int hold_ticket  = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left   = LONG_HOLD;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // moving average of the drift samples; a zero sample empties it
  function automatic logic signed [15:0] average_drift(input logic signed [15:0] sample);
    int sum;
    sum = 0;
    if (sample == 0) begin
      avg_wr  = '0;
      avg_cnt = '0;
      return '0;
    end
    avg_buf[avg_wr] = sample;
    avg_wr = (avg_wr == AVG_SLOTS - 1) ? '0 : avg_wr + 1'b1;
    if (avg_cnt < AVG_SLOTS) avg_cnt++;
    for (int i = 0; i < avg_cnt; i++) sum += avg_buf[i];
    return 16'(sum / int'(avg_cnt));
  endfunction

  // advance the predicted state by one event and return the expected result
  function automatic sync_result_t predict_event(input logic [1:0] kind,
                                                 input logic [15:0] ref_val,
                                                 input logic [15:0] loc_val);
    sync_result_t res;
    res = '0;
    case (kind)
      tdsc_pkg::OP_SYNC: begin
        if (first_pulse_pending) begin
          first_pulse_pending = 1'b0;
          res.load  = 1'b1;
          res.value = cfg_start;
        end
        res.clear  = 1'b1;
        pres_left  = cfg_presence;
        pulse_flag = 1'b1;
      end
      tdsc_pkg::OP_TICK: begin
        if (pres_left != 0) pres_left--;
        if (step_count != tdsc_pkg::STEP_MAX) step_count++;
        if (step_count >= cfg_period) fix_pending = 1'b1;
      end
      tdsc_pkg::OP_POLL: begin
        if (fix_pending && loc_val > cfg_win_lo && loc_val < cfg_win_hi) begin
          fix_pending = 1'b0;
          step_count  = '0;
          res.load    = 1'b1;
          if (pres_left != 0) begin
            // first sample after the cable comes back is dropped
            if (skip_sample) skip_sample = 1'b0;
            else corr_value = average_drift(signed'(ref_val - loc_val));
            res.value = ref_val;
          end else begin
            skip_sample = 1'b1;
            res.value   = loc_val + corr_value;
          end
        end
      end
      default: ;
    endcase
    res.corr    = corr_value;
    res.present = (pres_left != 0);
    res.seen    = pulse_flag;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    sync_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("load_local", 16'(want.load), 16'(load_local));
        check_field("new_local", want.value, new_local);
        check_field("clear_ref", 16'(want.clear), 16'(clear_ref));
        check_field("correction_out", want.corr, correction_out);
        check_field("cable_present", 16'(want.present), 16'(cable_present));
        check_field("sync_seen", 16'(want.seen), 16'(sync_seen));
      end
    end
  end

  // offer one event, wait for acceptance, then maybe leave a gap
  task automatic send_event(input logic [1:0] kind, input logic [15:0] ref_val,
                            input logic [15:0] loc_val);
    in_valid    <= 1'b1;
    op          <= kind;
    ref_count   <= ref_val;
    local_count <= loc_val;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_event(kind, ref_val, loc_val));
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      tdsc_pkg::REG_PRESENCE_RELOAD:   cfg_presence = val[7:0];
      tdsc_pkg::REG_CORRECTION_PERIOD: cfg_period   = val[15:0];
      tdsc_pkg::REG_WINDOW_LOW:        cfg_win_lo   = val[15:0];
      tdsc_pkg::REG_WINDOW_HIGH:       cfg_win_hi   = val[15:0];
      tdsc_pkg::REG_START_VALUE:       cfg_start    = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] presence, input logic [15:0] period,
                                input logic [15:0] win_lo, input logic [15:0] win_hi);
    wait_idle();
    write_reg(tdsc_pkg::REG_PRESENCE_RELOAD, 32'(presence));
    write_reg(tdsc_pkg::REG_CORRECTION_PERIOD, 32'(period));
    write_reg(tdsc_pkg::REG_WINDOW_LOW, 32'(win_lo));
    write_reg(tdsc_pkg::REG_WINDOW_HIGH, 32'(win_hi));
  endtask

  task automatic set_idling(input int sender, input int receiver);
    send_pct = sender;
    recv_pct = receiver;
  endtask

  // random traffic: mostly ticks and in-window polls with small drift
  task automatic send_random(input int count);
    logic [1:0]  kind;
    logic [15:0] ref_val;
    logic [15:0] loc_val;
    int          pick;
    int          lo;
    int          hi;
    int          drift;
    for (int n = 0; n < count; n++) begin
      pick    = $urandom_range(99);
      loc_val = 16'($urandom);
      ref_val = 16'($urandom);
      if (pick < 8) kind = tdsc_pkg::OP_SYNC;
      else if (pick < 53) kind = tdsc_pkg::OP_TICK;
      else if (pick < 95) kind = tdsc_pkg::OP_POLL;
      else kind = OP_UNKNOWN;
      if (kind == tdsc_pkg::OP_POLL) begin
        lo = int'(cfg_win_lo) + 1;
        hi = int'(cfg_win_hi) - 1;
        if (hi >= lo && $urandom_range(99) < 80) loc_val = 16'($urandom_range(hi, lo));
        pick = $urandom_range(99);
        if (pick < 10) drift = 0;
        else if (pick < 70) drift = int'($urandom_range(400)) - 200;
        else if (pick < 80) drift = 32768;
        else drift = $urandom_range(65535);
        ref_val = loc_val + drift[15:0];
      end
      send_event(kind, ref_val, loc_val);
    end
  endtask

  task automatic test_directed_events();
    set_idling(0, 0);
    // reset settings, nothing seen yet
    send_event(OP_UNKNOWN, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_POLL, 16'hFFFF, 16'h0000);
    send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'hFFFF);
    wait_idle();
    write_reg(tdsc_pkg::REG_START_VALUE, 32'h0000_FFFF);
    // first pulse loads the start value, the repeat does not
    send_event(tdsc_pkg::OP_SYNC, 16'h1234, 16'h5678);
    send_event(tdsc_pkg::OP_SYNC, 16'hFFFF, 16'hFFFF);
    send_event(OP_UNKNOWN, 16'hFFFF, 16'hFFFF);
    apply_settings(8'd4, 16'd1, 16'h0000, 16'hFFFF);
    send_event(tdsc_pkg::OP_SYNC, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_POLL, 16'd200, 16'd100);      // skipped sample
    send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_POLL, 16'd300, 16'd250);
    send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_POLL, 16'h8001, 16'h0001);    // most negative drift
    send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'h0000);    // cable times out
    send_event(tdsc_pkg::OP_POLL, 16'h0000, 16'h0000);    // on the low edge: no fix
    send_event(tdsc_pkg::OP_POLL, 16'h0000, 16'hFFFF);    // on the high edge: no fix
    send_event(tdsc_pkg::OP_POLL, 16'h0000, 16'hFFFE);    // absent: add correction
    send_event(tdsc_pkg::OP_SYNC, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_POLL, 16'd500, 16'd400);      // skipped after return
    send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_POLL, 16'h7FFF, 16'h7FFF);    // zero drift clears average
  endtask

  task automatic test_window_tracking();
    apply_settings(8'd6, 16'd2, 16'd100, 16'd65000);
    set_idling(0, 0);
    send_random(330);
  endtask

  task automatic test_long_presence();
    apply_settings(8'd255, 16'd1, 16'h0000, 16'hFFFF);
    set_idling(56, 0);
    send_random(450);
  endtask

  // zero period: every tick requests a fix
  task automatic test_short_presence();
    apply_settings(8'd1, 16'd0, 16'd30000, 16'd40000);
    write_reg(tdsc_pkg::REG_START_VALUE, 32'h0000_0000);
    set_idling(0, 56);
    send_random(350);
  endtask

  task automatic test_degenerate_windows();
    set_idling(35, 35);
    apply_settings(8'd20, 16'd5, 16'd40000, 16'd20000);   // inverted
    send_random(120);
    apply_settings(8'd3, 16'd2, 16'd500, 16'd500);        // empty
    send_random(80);
    apply_settings(8'd0, 16'd1, 16'd500, 16'd501);        // no value strictly inside
    send_random(80);
  endtask

  task automatic test_mixed_traffic();
    apply_settings(8'd12, 16'd4, 16'h0000, 16'hFFFF);
    set_idling(35, 35);
    send_random(320);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    apply_settings(8'd30, 16'd2, 16'd10, 16'd65500);
    set_idling(0, 0);
    hold_ticket <= hold_ticket + 1;
    send_random(48);
  endtask

  // count well past the period, then take the fix
  task automatic test_period_overrun();
    apply_settings(8'd255, 16'd40, 16'h0000, 16'hFFFF);
    set_idling(0, 0);
    send_event(tdsc_pkg::OP_SYNC, 16'h0000, 16'h0000);
    repeat (45) send_event(tdsc_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_event(tdsc_pkg::OP_POLL, 16'h4000, 16'h3FF0);
    send_event(tdsc_pkg::OP_POLL, 16'h4000, 16'h3FF0);    // request already consumed
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_events();
    test_window_tracking();
    test_long_presence();
    test_short_presence();
    test_degenerate_windows();
    test_mixed_traffic();
    test_output_backpressure();
    test_period_overrun();
    wait_idle();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
